@@ src/spts_pkg.sv @@
// shared types and constants for the sparse polynomial term store
// used by spts_ctrl, spts_datapath and sparse_polynomial_term_store
package spts_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int DEG_W     = 6;
  localparam int VAL_W     = 32;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_EVAL  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [DEG_W-1:0]        deg;
    logic signed [VAL_W-1:0] coef;
  } entry_t;

  typedef struct packed {
    logic init;
    logic capture;
    logic step;
    logic set_pos;
    logic acc;
    logic rd_prev;
    logic shift;
    logic ins;
    logic full;
    logic mul;
    logic horner;
    logic load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    i_eq_count;
    logic    i_eq_pos;
    logic    eq;
    logic    lt;
    logic    full;
    logic    d_zero;
    logic    out_busy;
  } stat_t;

endpackage

@@ src/spts_ctrl.sv @@
// sequencer for add, evaluate and clear transactions
// depends on spts_pkg; drives spts_datapath through cmd_t and reads stat_t
module spts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  spts_pkg::stat_t st,
  output spts_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_ADD_RD, S_ADD_CMP, S_SH_RD, S_SH_WR, S_INS,
    S_EV_MUL, S_EV_ADD, S_DONE
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          unique case (st.act)
            spts_pkg::ACT_ADD:   state_next = S_ADD_RD;
            spts_pkg::ACT_EVAL:  state_next = S_EV_MUL;
            spts_pkg::ACT_CLEAR: state_next = S_CLR;
            spts_pkg::ACT_NONE:  state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd.init   = 1'b1;
        state_next = S_DONE;
      end
      S_ADD_RD: begin
        if (st.i_eq_count) begin
          if (st.full) begin
            cmd.full   = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.set_pos = 1'b1;
            state_next  = S_SH_RD;
          end
        end else begin
          state_next = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        priority if (st.eq) begin
          cmd.acc    = 1'b1;
          state_next = S_DONE;
        end else if (st.lt) begin
          if (st.full) begin
            cmd.full   = 1'b1;
            state_next = S_DONE;
          end else begin
            cmd.set_pos = 1'b1;
            state_next  = S_SH_RD;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = S_ADD_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_prev = 1'b1;
        state_next  = st.i_eq_pos ? S_INS : S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift  = 1'b1;
        state_next = S_SH_RD;
      end
      S_INS: begin
        cmd.ins    = 1'b1;
        state_next = S_DONE;
      end
      S_EV_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EV_ADD;
      end
      S_EV_ADD: begin
        cmd.horner = 1'b1;
        state_next = st.d_zero ? S_DONE : S_EV_MUL;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> !st.full) else $error("insert into full table");
  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> !st.i_eq_pos) else $error("shift below insert position");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !st.out_busy) else $error("result register overwritten");

endmodule

@@ src/spts_datapath.sv @@
// term table memory, scan and shift index, horner multiply and saturation
// depends on spts_pkg; commanded by spts_ctrl
module spts_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spts_pkg::cmd_t                       cmd,
  output spts_pkg::stat_t                      st,
  input  logic [1:0]                           action,
  input  logic signed [spts_pkg::VAL_W-1:0]    term_coefficient,
  input  logic [spts_pkg::DEG_W-1:0]           term_degree,
  input  logic signed [spts_pkg::VAL_W-1:0]    point,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [spts_pkg::VAL_W-1:0]    value,
  output logic [spts_pkg::DEG_W-1:0]           highest_degree,
  output logic [spts_pkg::CNT_W-1:0]           term_count,
  output logic [1:0]                           status
);

  localparam int IW = spts_pkg::IDX_W;
  localparam int CW = spts_pkg::CNT_W;
  localparam int DW = spts_pkg::DEG_W;
  localparam int VW = spts_pkg::VAL_W;
  localparam logic signed [2*VW-1:0] Q_HI = (2*VW)'(64'sh000000007fffffff);
  localparam logic signed [2*VW-1:0] Q_LO = (2*VW)'(64'shffffffff80000000);
  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  spts_pkg::entry_t mem [spts_pkg::MAX_TERMS];
  spts_pkg::entry_t rdata, wdata;
  logic [IW-1:0]    raddr, waddr;
  logic             we;

  spts_pkg::action_t       act_r;
  logic signed [VW-1:0]    coef_r, x_r, r;
  logic [DW-1:0]           deg_r, top, d;
  logic [CW-1:0]           i, pos, count;
  logic signed [2*VW-1:0]  prod, q;
  logic                    sat, full_flag;

  logic signed [VW:0]      acc_sum, h_sum;
  logic signed [VW-1:0]    acc_val, qs, h_val;
  logic                    acc_ovf, q_ovf, h_ovf, match;

  always_comb begin
    acc_sum = {rdata.coef[VW-1], rdata.coef} + {coef_r[VW-1], coef_r};
    acc_ovf = acc_sum[VW] != acc_sum[VW-1];
    acc_val = acc_ovf ? (acc_sum[VW] ? V_MIN : V_MAX) : acc_sum[VW-1:0];

    q     = prod >>> spts_pkg::FRAC_BITS;
    q_ovf = (q > Q_HI) || (q < Q_LO);
    qs    = (q > Q_HI) ? V_MAX : ((q < Q_LO) ? V_MIN : q[VW-1:0]);
    match = (i < count) && (rdata.deg == d);
    h_sum = {qs[VW-1], qs} + {rdata.coef[VW-1], rdata.coef};
    h_ovf = match && (h_sum[VW] != h_sum[VW-1]);
    h_val = (h_sum[VW] != h_sum[VW-1]) ? (h_sum[VW] ? V_MIN : V_MAX) : h_sum[VW-1:0];
  end

  assign raddr = cmd.rd_prev ? IW'(i - CW'(1)) : i[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = i[IW-1:0];
    wdata = rdata;
    priority if (cmd.init) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end else if (cmd.acc) begin
      we    = 1'b1;
      wdata = '{deg: rdata.deg, coef: acc_val};
    end else if (cmd.shift) begin
      we    = 1'b1;
    end else if (cmd.ins) begin
      we    = 1'b1;
      waddr = pos[IW-1:0];
      wdata = '{deg: deg_r, coef: coef_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= spts_pkg::action_t'(action);
      coef_r <= term_coefficient;
      deg_r  <= term_degree;
      x_r    <= point;
      r      <= '0;
      d      <= top;
    end
    if (cmd.mul) begin
      prod <= r * x_r;
    end
    if (cmd.horner) begin
      r <= match ? h_val : qs;
      d <= d - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      pos       <= '0;
      count     <= CW'(1);
      top       <= '0;
      sat       <= 1'b0;
      full_flag <= 1'b0;
    end else begin
      if (cmd.capture) begin
        i         <= '0;
        sat       <= 1'b0;
        full_flag <= 1'b0;
      end
      if (cmd.init) begin
        count <= CW'(1);
        top   <= '0;
      end
      if (cmd.step) begin
        i <= i + CW'(1);
      end
      if (cmd.set_pos) begin
        pos <= i;
        i   <= count;
      end
      if (cmd.shift) begin
        i <= i - CW'(1);
      end
      if (cmd.acc && acc_ovf) begin
        sat <= 1'b1;
      end
      if (cmd.ins) begin
        count <= count + CW'(1);
        if (pos == '0) begin
          top <= deg_r;
        end
      end
      if (cmd.full) begin
        full_flag <= 1'b1;
      end
      if (cmd.horner) begin
        if (match) begin
          i <= i + CW'(1);
        end
        if (q_ovf || h_ovf) begin
          sat <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value          <= r;
      highest_degree <= top;
      term_count     <= count;
      status         <= full_flag ? spts_pkg::ST_FULL :
                        (sat ? spts_pkg::ST_SAT : spts_pkg::ST_OK);
    end
  end

  always_comb begin
    st.act        = spts_pkg::action_t'(action);
    st.i_eq_count = (i == count);
    st.i_eq_pos   = (i == pos);
    st.eq         = (rdata.deg == deg_r);
    st.lt         = (rdata.deg < deg_r);
    st.full       = (count == CW'(spts_pkg::MAX_TERMS));
    st.d_zero     = (d == '0);
    st.out_busy   = result_valid && result_stall;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(spts_pkg::MAX_TERMS)))
    else $error("term count out of range");
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    i <= count) else $error("index beyond stored terms");
  a_clear_action: assert property (@(posedge clk) disable iff (rst)
    (cmd.init && !$past(rst) && $past(cmd.capture)) |-> (act_r == spts_pkg::ACT_CLEAR))
    else $error("table cleared outside clear transaction");

endmodule

@@ src/sparse_polynomial_term_store.sv @@
// Sparse polynomial term store: holds up to 16 (degree, coefficient) terms in falling
// degree order and adds terms, clears, or evaluates by Horner in signed Q16.16 with
// saturation. One transaction at a time; each gives one result. An add scans the table
// term by term up to the matching or insert position, then shifts the tail one entry
// at a time; an evaluate steps one degree at a time from the highest stored degree
// down to zero through one shared 32x32 multiplier; a clear reinitializes the table.
// After reset the S_INIT state initializes the table.
module sparse_polynomial_term_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [1:0]                         action,
  input  logic signed [spts_pkg::VAL_W-1:0]  term_coefficient,
  input  logic [spts_pkg::DEG_W-1:0]         term_degree,
  input  logic signed [spts_pkg::VAL_W-1:0]  point,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [spts_pkg::VAL_W-1:0]  value,
  output logic [spts_pkg::DEG_W-1:0]         highest_degree,
  output logic [spts_pkg::CNT_W-1:0]         term_count,
  output logic [1:0]                         status
);

  spts_pkg::cmd_t  cmd;
  spts_pkg::stat_t st;

  spts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  spts_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .action           (action),
    .term_coefficient (term_coefficient),
    .term_degree      (term_degree),
    .point            (point),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .value            (value),
    .highest_degree   (highest_degree),
    .term_count       (term_count),
    .status           (status)
  );

endmodule

@@ sim/tb_top.sv @@
// testbench for sparse_polynomial_term_store: random and directed add, evaluate and clear
// transactions checked against an in-bench model of the term table and Horner evaluation
// depends on spts_pkg and the rtl top level
module tb_top;

  typedef struct packed {
    logic signed [31:0] val;
    logic [5:0]         hdeg;
    logic [4:0]         cnt;
    logic [1:0]         st;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] action = spts_pkg::ACT_ADD;
  logic signed [31:0] term_coefficient = '0;
  logic [5:0] term_degree = '0;
  logic signed [31:0] point = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] value;
  logic [5:0] highest_degree;
  logic [4:0] term_count;
  logic [1:0] status;

  sparse_polynomial_term_store DUT (.*);

  always #6 clk = ~clk;

  logic [5:0] deg_tab [spts_pkg::MAX_TERMS];
  logic signed [31:0] coef_tab [spts_pkg::MAX_TERMS];
  int n_terms;
  poly_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v, inout bit sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b, inout bit sat);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    p = p >>> spts_pkg::FRAC_BITS;
    return clamp32(p, sat);
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < spts_pkg::MAX_TERMS; i++) begin
      deg_tab[i] = '0;
      coef_tab[i] = '0;
    end
    n_terms = 1;
  endfunction

  function automatic poly_result_t apply_transaction(input logic [1:0] act,
      input logic signed [31:0] c, input logic [5:0] d, input logic signed [31:0] x);
    poly_result_t r;
    bit sat;
    bit found;
    int pos;
    int idx;
    logic signed [31:0] acc;
    r = '0;
    sat = 1'b0;
    found = 1'b0;
    if (act == spts_pkg::ACT_ADD) begin
      for (int i = 0; i < n_terms; i++) begin
        if (!found && deg_tab[i] == d) begin
          coef_tab[i] = clamp32(66'(coef_tab[i]) + 66'(c), sat);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (n_terms >= spts_pkg::MAX_TERMS) begin
          r.st = spts_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < n_terms && deg_tab[pos] > d) pos++;
          for (int i = n_terms; i > pos; i--) begin
            deg_tab[i] = deg_tab[i-1];
            coef_tab[i] = coef_tab[i-1];
          end
          deg_tab[pos] = d;
          coef_tab[pos] = c;
          n_terms++;
        end
      end
      if (sat) r.st = spts_pkg::ST_SAT;
    end else if (act == spts_pkg::ACT_EVAL) begin
      acc = '0;
      idx = 0;
      for (int k = deg_tab[0]; k >= 0; k--) begin
        acc = fix_mul(acc, x, sat);
        if (idx < n_terms && deg_tab[idx] == k) begin
          acc = clamp32(66'(acc) + 66'(coef_tab[idx]), sat);
          idx++;
        end
      end
      r.val = acc;
      if (sat) r.st = spts_pkg::ST_SAT;
    end else if (act == spts_pkg::ACT_CLEAR) begin
      table_reset();
    end
    r.hdeg = deg_tab[0];
    r.cnt = 5'(n_terms);
    return r;
  endfunction

  task automatic send_transaction(input logic [1:0] act, input logic signed [31:0] c,
                                  input logic [5:0] d, input logic signed [31:0] x);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    action <= act;
    term_coefficient <= c;
    term_degree <= d;
    point <= x;
    item_valid <= 1'b1;
    pending_results.push_back(apply_transaction(act, c, d, x));
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(4))
      0: return 32'($urandom_range(131072)) - 32'sd65536;
      1: return 32'($urandom_range(32768)) - 32'sd16384;
      2: return $urandom;
      3: return 32'($urandom_range(4)) <<< 16;
      default: return -(32'($urandom_range(2)) <<< 16);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(1048576)) - 32'sd524288;
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(8)) <<< 16;
    endcase
  endfunction

  task automatic test_directed();
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'h7fffffff);
    send_transaction(spts_pkg::ACT_ADD, 32'h7fffffff, 0, 0);
    send_transaction(spts_pkg::ACT_ADD, 32'h7fffffff, 0, 0);
    send_transaction(spts_pkg::ACT_ADD, 32'h80000000, 0, 0);
    send_transaction(spts_pkg::ACT_ADD, 32'h80000000, 0, 0);
    send_transaction(spts_pkg::ACT_ADD, 32'h00010000, 63, 0);
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'hffff0000);
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'h80000000);
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'hffffffff);
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'h7fffffff);
    send_transaction(spts_pkg::ACT_NONE, 32'hffffffff, 6'h3f, 32'hffffffff);
    send_transaction(spts_pkg::ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 17; i++)
      send_transaction(spts_pkg::ACT_ADD, 32'h00008000, 6'(2 * i + 1), 0);
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'hfffeffff);
    send_transaction(spts_pkg::ACT_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random(input int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 55) send_transaction(spts_pkg::ACT_ADD, rand_coef(),
                                   $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(12)), 0);
      else if (r < 88) send_transaction(spts_pkg::ACT_EVAL, 0, 6'($urandom), rand_point());
      else if (r < 95) send_transaction(spts_pkg::ACT_CLEAR, $urandom, 6'($urandom), $urandom);
      else send_transaction(spts_pkg::ACT_NONE, $urandom, 6'($urandom), $urandom);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 6; i++)
      send_transaction(spts_pkg::ACT_ADD, rand_coef(), 6'($urandom_range(8)), 0);
    wait_drained();
    send_transaction(spts_pkg::ACT_EVAL, 0, 0, 32'h00010000);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    poly_result_t want;
    poly_result_t got;
    cycles <= cycles + 1;
    if (!rst && result_valid && !result_stall) begin
      got = '{value, highest_degree, term_count, status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("FAIL sparse_polynomial_term_store");
      $finish;
    end
  end

  initial begin
    table_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 54;
    test_directed();
    test_random(330);
    test_backpressure();
    send_idle_pct = 54;
    recv_idle_pct = 34;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);
    wait_drained();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS sparse_polynomial_term_store");
    else
      $display("FAIL sparse_polynomial_term_store");
    $finish;
  end
endmodule

@@ sim.f @@
src/spts_pkg.sv
src/spts_ctrl.sv
src/spts_datapath.sv
src/sparse_polynomial_term_store.sv
sim/tb_top.sv
